// File: hw/rtl/cmac_pkg.sv
// Package for the AES-128 CMAC tag block: payload and config types,
// S-box table, round helpers and config register indexes. No dependencies.
package cmac_pkg;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic [4:0]  byte_count;
		logic        final_block;
	} cmac_in_t;

	typedef struct packed {
		logic [63:0] tag_high;
		logic [63:0] tag_low;
	} cmac_out_t;

	localparam logic [0:0] REG_KEY_HIGH = 1'd0;
	localparam logic [0:0] REG_KEY_LOW  = 1'd1;
	localparam logic [7:0] GF_POLY = 8'h87;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Control from the sequencer to the round unit
	typedef struct packed {
		logic load;      // load state with data ^ key0
		logic step;      // run one round
		logic last;      // final round: no MixColumns
	} cmac_rnd_ctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a 128-bit word, byte 0 most significant
	function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
		return w[127 - 8*i -: 8];
	endfunction

	// Key schedule step: next round key from the current one and rcon
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// GF(2^128) doubling
	function automatic logic [127:0] gf_dbl(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ {120'd0, v[127] ? GF_POLY : 8'h00};
	endfunction

endpackage

// File: hw/rtl/cmac_round.sv
// AES round unit: one round per cycle on a 128-bit state, with the
// round key generated on the fly alongside. Depends on cmac_pkg.
module cmac_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmac_pkg::cmac_rnd_ctl_t ctl,
	input  logic [127:0]           data,
	input  logic [127:0]           key,
	input  logic [7:0]             rcon,
	output logic [127:0]           state
);
	import cmac_pkg::*;

	logic [127:0] state_q, rkey_q, rk_next, sb, mc, nxt;

	// SubBytes + ShiftRows
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				sb[127 - 8*(4*c+i) -: 8] = sbox(byte_of(state_q, 4*((c+i)%4)+i));
			end
		end
	end

	// MixColumns
	always_comb begin
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_of(sb, 4*c); a1 = byte_of(sb, 4*c+1);
			a2 = byte_of(sb, 4*c+2); a3 = byte_of(sb, 4*c+3);
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
				a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
		end
	end

	assign rk_next = next_key(rkey_q, rcon);
	assign nxt = (ctl.last ? sb : mc) ^ rk_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			rkey_q  <= '0;
		end else if (ctl.load) begin
			state_q <= data ^ key;
			rkey_q  <= key;
		end else if (ctl.step) begin
			state_q <= nxt;
			rkey_q  <= rk_next;
		end
	end

	assign state = state_q;
endmodule

// File: hw/rtl/aes_cmac_tag.sv
// Top level of the AES-128 CMAC tag block: channel handshakes, key
// registers, subkeys, chain and sequencer. Depends on cmac_pkg, cmac_round.
//
// Usage: write key_high (index 0) and key_low (index 1) through the
// cfg write port while idle. Feed message blocks on in_valid/in_ready,
// byte 0 in the top byte of block_high; final_block marks the last one,
// whose byte_count (0..16, larger counts as 16) selects full or padded.
// After a final block one tag item appears on out_valid/out_ready.
// Sequence: after the accept cycle a block passes through the round
// unit (load, ten rounds, chain update), and in_ready stays low until
// it is done. The first block of a message is preceded by the subkey
// encryption of zero. A tag is loaded into the output register after
// its final block's chain update. The single round unit, one round per
// cycle, runs every encryption. in_ready is high only in the
// idle state. While a tag waits on a stalled receiver it is held in the
// output register and the block still takes the next block; a second tag
// waits in the sequencer, with in_ready low, until that register frees.
// Reset clears the key, subkeys, chain and the message flag; round keys
// are derived from the key on every block.
module aes_cmac_tag (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cmac_pkg::cmac_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cmac_pkg::cmac_out_t  out_data,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [63:0]          cfg_data
);
	import cmac_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUBK = 4'b0010,
		ST_ENC  = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t st_q;
	logic [3:0] rnd_q;
	logic [7:0] rcon_q;
	logic [127:0] key_q, chain_q, k1_q, k2_q, blk_q, aes_out, ld_data, padded, mask;
	logic [4:0] cnt_q;
	logic fin_q, in_msg_q, started_q;
	cmac_rnd_ctl_t ctl;

	// Pad the final partial block: byte count kept, 0x80 then zeros
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (i < cnt_q) mask[127 - 8*i -: 8] = byte_of(blk_q, i);
			else if (i == cnt_q) mask[127 - 8*i -: 8] = PAD_BYTE;
			else mask[127 - 8*i -: 8] = 8'h00;
		end
		padded = mask;
	end

	always_comb begin
		if (!fin_q) ld_data = chain_q ^ blk_q;
		else if (cnt_q >= 5'd16) ld_data = chain_q ^ blk_q ^ k1_q;
		else ld_data = chain_q ^ padded ^ k2_q;
	end

	// Sequencer controls for the round unit
	always_comb begin
		ctl.load = 1'b0;
		ctl.step = 1'b0;
		ctl.last = (rnd_q == 4'd10);
		if ((st_q == ST_SUBK || st_q == ST_ENC) && !started_q) ctl.load = 1'b1;
		else if ((st_q == ST_SUBK || st_q == ST_ENC) && rnd_q <= 4'd10) ctl.step = 1'b1;
	end

	cmac_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.data(st_q == ST_SUBK ? 128'd0 : ld_data),
		.key(key_q), .rcon(rcon_q), .state(aes_out)
	);

	assign in_ready = (st_q == ST_IDLE);

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_q[127:64] <= cfg_data;
				REG_KEY_LOW:  key_q[63:0]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Block capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blk_q <= {in_data.block_high, in_data.block_low};
			cnt_q <= in_data.byte_count;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rnd_q <= '0;
			rcon_q <= 8'h01;
			started_q <= 1'b0;
			fin_q <= 1'b0;
			in_msg_q <= 1'b0;
			chain_q <= '0;
			k1_q <= '0;
			k2_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			// tag taken; a tag loaded from ST_DONE sets valid below
			if (out_valid && out_ready && st_q != ST_DONE) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					started_q <= 1'b0;
					rnd_q <= 4'd1;
					rcon_q <= 8'h01;
					if (in_valid) begin
						fin_q <= in_data.final_block;
						st_q <= in_msg_q ? ST_ENC : ST_SUBK;
					end
				end
				ST_SUBK, ST_ENC: begin
					if (!started_q) begin
						started_q <= 1'b1;
					end else if (rnd_q <= 4'd10) begin
						rnd_q <= rnd_q + 4'd1;
						rcon_q <= xtime(rcon_q);
					end else begin
						started_q <= 1'b0;
						rnd_q <= 4'd1;
						rcon_q <= 8'h01;
						if (st_q == ST_SUBK) begin
							k1_q <= gf_dbl(aes_out);
							k2_q <= gf_dbl(gf_dbl(aes_out));
							chain_q <= '0;
							in_msg_q <= 1'b1;
							st_q <= ST_ENC;
						end else begin
							chain_q <= aes_out;
							st_q <= fin_q ? ST_DONE : ST_IDLE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_data <= {aes_out[127:64], aes_out[63:0]};
						in_msg_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: bench/cmac_tag_checker.sv
// Checker for the AES-128 CMAC tag block: watches the block and tag channels,
// predicts tags from the key registers and compares. Depends on cmac_pkg.
module cmac_tag_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  cmac_pkg::cmac_in_t   in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  cmac_pkg::cmac_out_t  out_data,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	output int                   fail_count,
	output int                   tags_pending
);
	import cmac_pkg::*;

	logic [127:0] aes_key;
	logic [127:0] chain;
	logic [127:0] k1;
	logic [127:0] k2;
	logic         mid_message;
	cmac_out_t    tag_queue[$];

	// Byte-wise S-box and MixColumns, written independently of the package
	function automatic logic [7:0] sub_byte(input logic [7:0] x);
		logic [7:0] tbl [256];
		tbl = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return tbl[x];
	endfunction

	function automatic logic [7:0] mul2(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Full AES-128 encryption of one 128-bit word, byte 0 in the top bits
	function automatic logic [127:0] encrypt_block(input logic [127:0] key,
	                                               input logic [127:0] pt);
		logic [7:0]  st [16];
		logic [7:0]  sh [16];
		logic [7:0]  rk [16];
		logic [7:0]  tmp [4];
		logic [7:0]  rc;
		logic [7:0]  a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) begin
			st[i] = pt[127 - 8*i -: 8];
			rk[i] = key[127 - 8*i -: 8];
			st[i] = st[i] ^ rk[i];
		end
		rc = 8'h01;
		for (int r = 1; r <= 10; r++) begin
			// next round key
			tmp[0] = sub_byte(rk[13]) ^ rc;
			tmp[1] = sub_byte(rk[14]);
			tmp[2] = sub_byte(rk[15]);
			tmp[3] = sub_byte(rk[12]);
			for (int w = 0; w < 4; w++)
				for (int j = 0; j < 4; j++) begin
					rk[4*w + j] = rk[4*w + j] ^ tmp[j];
					tmp[j] = rk[4*w + j];
				end
			rc = mul2(rc);
			// SubBytes and ShiftRows
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					sh[4*c + j] = sub_byte(st[4*((c + j) & 3) + j]);
			for (int c = 0; c < 4; c++) begin
				a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
				if (r < 10) begin
					all = a0 ^ a1 ^ a2 ^ a3;
					st[4*c]   = a0 ^ all ^ mul2(a0 ^ a1);
					st[4*c+1] = a1 ^ all ^ mul2(a1 ^ a2);
					st[4*c+2] = a2 ^ all ^ mul2(a2 ^ a3);
					st[4*c+3] = a3 ^ all ^ mul2(a3 ^ a0);
				end else begin
					st[4*c] = a0; st[4*c+1] = a1; st[4*c+2] = a2; st[4*c+3] = a3;
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] = st[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++)
			res[127 - 8*i -: 8] = st[i];
		return res;
	endfunction

	function automatic logic [127:0] times_x(input logic [127:0] v);
		logic [127:0] d;
		d = v << 1;
		if (v[127])
			d[7:0] = d[7:0] ^ 8'h87;
		return d;
	endfunction

	// Apply one accepted block; queue a tag after a final block
	task automatic absorb_block(input cmac_in_t blk);
		logic [127:0] data;
		logic [127:0] lval;
		int           n;
		data = {blk.block_high, blk.block_low};
		n = int'(blk.byte_count);
		if (!mid_message) begin
			lval = encrypt_block(aes_key, '0);
			k1 = times_x(lval);
			k2 = times_x(times_x(lval));
			chain = '0;
			mid_message = 1'b1;
		end
		if (blk.final_block) begin
			if (n >= 16) begin
				data = data ^ k1;
			end else begin
				data[127 - 8*n -: 8] = PAD_BYTE;
				for (int i = n + 1; i < 16; i++)
					data[127 - 8*i -: 8] = 8'h00;
				data = data ^ k2;
			end
		end
		chain = encrypt_block(aes_key, chain ^ data);
		if (blk.final_block) begin
			tag_queue.push_back('{tag_high: chain[127:64], tag_low: chain[63:0]});
			mid_message = 1'b0;
		end
	endtask

	assign tags_pending = tag_queue.size();

	// Track key writes, blocks and tags
	always @(posedge clk or negedge arst_n) begin
		cmac_out_t want;
		if (!arst_n) begin
			aes_key <= '0;
			chain = '0;
			k1 = '0;
			k2 = '0;
			mid_message = 1'b0;
			tag_queue.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_KEY_HIGH)
					aes_key[127:64] <= cfg_data;
				else
					aes_key[63:0] <= cfg_data;
			end
			if (in_valid && in_ready)
				absorb_block(in_data);
			if (out_valid && out_ready) begin
				if (tag_queue.size() == 0) begin
					if (fail_count < 10)
						$display("tag with none expected: %h %h",
							out_data.tag_high, out_data.tag_low);
					fail_count <= fail_count + 1;
				end else begin
					want = tag_queue.pop_front();
					if (want != out_data) begin
						if (fail_count < 10)
							$display("tag mismatch: expected %h %h, got %h %h",
								want.tag_high, want.tag_low,
								out_data.tag_high, out_data.tag_low);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: bench/tb_aes_cmac_tag.sv
// Testbench top for the AES-128 CMAC tag block: clock, reset, key writes,
// message stimulus and verdict. Depends on cmac_pkg, aes_cmac_tag, cmac_tag_checker.
module tb_aes_cmac_tag;
	import cmac_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	cmac_in_t    in_data;
	logic        out_valid;
	logic        out_ready;
	cmac_out_t   out_data;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          tags_pending;
	int          burst_left;
	int          stall_mode;

	aes_cmac_tag i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_data
	);

	cmac_tag_checker i_checker (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_data,
		.fail_count, .tags_pending
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver stall pattern; mode 0 never stalls
	always @(posedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Send one block; valid stays high within a burst, gaps between bursts
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
	                          input logic [4:0] cnt, input logic fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= '{block_high: hi, block_low: lo, byte_count: cnt, final_block: fin};
		do @(posedge clk); while (!in_ready);
		if (burst_left == 0)
			in_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// End any open burst, wait for all tags, then let the block settle
	task automatic drain();
		if (burst_left != 0) begin
			in_valid <= 1'b0;
			burst_left = 0;
		end
		while (tags_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
		cfg_we <= 1'b1;
		cfg_index <= REG_KEY_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= REG_KEY_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random message of 1..len blocks, mostly well-formed
	task automatic random_message(input int len);
		int n;
		n = $urandom_range(1, len);
		for (int b = 0; b < n; b++)
			send_block(rand64(), rand64(), 5'($urandom_range(0, 31)), b == n - 1);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		burst_left = 0;
		stall_mode = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset key, single blocks across counts, empty and oversized
		send_block('0, '0, 5'd0, 1'b1);
		send_block('1, '1, 5'd16, 1'b1);
		send_block('1, '1, 5'd31, 1'b1);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7, 1'b1);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b1);
		drain();
		write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
		send_block('0, '0, 5'd0, 1'b1);
		send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
		// multi-block with ignored counts, then empty final block
		send_block('1, '0, 5'd3, 1'b0);
		send_block('0, '1, 5'd0, 1'b0);
		send_block('0, '0, 5'd0, 1'b1);
		send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd31, 1'b0);
		send_block(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd9, 1'b1);
		drain();
		write_key('1, '1);
		send_block('1, '1, 5'd1, 1'b1);
		send_block('0, '0, 5'd16, 1'b0);
		send_block('1, '1, 5'd17, 1'b1);
		drain();

		// Random phases under different keys and stall patterns
		for (int ph = 0; ph < 6; ph++) begin
			stall_mode = ph % 3;
			write_key(rand64(), rand64());
			repeat (60)
				random_message(ph == 5 ? 2 : 10);
			drain();
		end
		// Mid-message key change: the new key applies to later blocks
		for (int m = 0; m < 40; m++) begin
			send_block(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b0);
			drain();
			write_key(rand64(), rand64());
			send_block(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b1);
		end
		drain();
		write_key('0, '0);
		repeat (20)
			random_message(4);
		drain();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
